// File: hdl/ssd_pkg.sv
package ssd_pkg;

  typedef enum logic [2:0] {
    KIND_NEW      = 3'd0,
    KIND_EXTENDED = 3'd1,
    KIND_RESTART  = 3'd2,
    KIND_BELOW    = 3'd3,
    KIND_FULL     = 3'd4,
    KIND_EVICTED  = 3'd5
  } kind_t;

  typedef enum logic [1:0] {
    OP_NONE    = 2'd0,
    OP_RESTART = 2'd1,
    OP_EXTEND  = 2'd2,
    OP_OPEN    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    REG_THRESHOLD = 2'd0,
    REG_PERIOD    = 2'd1,
    REG_IDLE      = 2'd2,
    REG_REPORT    = 2'd3
  } reg_t;

  typedef struct packed {
    logic [31:0] start;
    logic [31:0] length;
    logic [15:0] repeats;
    logic [31:0] open_time;
    logic [31:0] touch_time;
  } entry_t;

  // broadcast from the control to every cell
  typedef struct packed {
    op_t         op;
    logic [31:0] addr;
    logic [31:0] ts;
    logic [31:0] event_num;
    logic [15:0] idle_limit;
    logic        sweep;
    logic        mark;
  } cell_cmd_t;

  // lookup chain passed from cell to cell, lowest index first
  typedef struct packed {
    logic       start_seen;
    logic       ext_seen;
    logic       free_seen;
    logic [1:0] doom_cnt;
  } chain_t;

endpackage

// File: hdl/ssd_cell.sv
module ssd_cell
  import ssd_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  cell_cmd_t cmd,
  input  logic      pick,
  input  logic      kill,
  input  chain_t    chain_in,
  output chain_t    chain_out,
  output entry_t    entry,
  output logic      start_first,
  output logic      ext_first,
  output logic      free_first,
  output logic      doom_first,
  output logic      doom_now
);

  logic        valid;
  logic        doomed;
  logic [31:0] last_event;
  logic [31:0] idle_span;
  logic        start_hit;
  logic        ext_hit;

  // local match against the request address
  assign start_hit = valid && (entry.start == cmd.addr);
  assign ext_hit   = valid && ((entry.start + entry.length) == cmd.addr);
  assign idle_span = cmd.event_num - last_event;

  assign start_first = start_hit && !chain_in.start_seen;
  assign ext_first   = ext_hit && !chain_in.ext_seen;
  assign free_first  = !valid && !chain_in.free_seen;
  assign doom_first  = doomed && (chain_in.doom_cnt == 2'd0);
  assign doom_now    = cmd.sweep && valid && (idle_span > {16'd0, cmd.idle_limit}) &&
                       !(pick && (cmd.op != OP_NONE));

  // hand the chain to the next cell
  always_comb begin
    chain_out.start_seen = chain_in.start_seen | start_hit;
    chain_out.ext_seen   = chain_in.ext_seen | ext_hit;
    chain_out.free_seen  = chain_in.free_seen | !valid;
    if (doomed && (chain_in.doom_cnt != 2'd2)) begin
      chain_out.doom_cnt = chain_in.doom_cnt + 2'd1;
    end else begin
      chain_out.doom_cnt = chain_in.doom_cnt;
    end
  end

  // control bits
  always_ff @(posedge clk) begin
    if (rst) begin
      valid  <= 1'b0;
      doomed <= 1'b0;
    end else if (kill) begin
      valid  <= 1'b0;
      doomed <= 1'b0;
    end else begin
      if (pick && (cmd.op == OP_OPEN)) begin
        valid <= 1'b1;
      end
      if (cmd.mark) begin
        doomed <= doom_now;
      end
    end
  end

  // entry payload
  always_ff @(posedge clk) begin
    if (pick) begin
      case (cmd.op)
        OP_RESTART: begin
          if (entry.repeats != 16'hFFFF) begin
            entry.repeats <= entry.repeats + 16'd1;
          end
          entry.length     <= 32'd1;
          entry.touch_time <= cmd.ts;
          last_event       <= cmd.event_num;
        end
        OP_EXTEND: begin
          if (entry.length != 32'hFFFF_FFFF) begin
            entry.length <= entry.length + 32'd1;
          end
          entry.touch_time <= cmd.ts;
          last_event       <= cmd.event_num;
        end
        OP_OPEN: begin
          entry.start      <= cmd.addr;
          entry.length     <= 32'd1;
          entry.repeats    <= 16'd0;
          entry.open_time  <= cmd.ts;
          entry.touch_time <= cmd.ts;
          last_event       <= cmd.event_num;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// File: hdl/sequential_stream_detector.sv
// Sequential write stream detector.
// Input channel s_*: one write request per transfer, tdata = {timestamp, address}.
// Output channel m_*: result requests; tuser carries the kind, tlast marks the
// final result caused by one write.
// Each write gives one primary result (new, extended, restarted, below
// threshold, table full). Every sweep_period writes, streams idle longer than
// idle_limit writes are evicted; with report_removals set each eviction yields
// one more result, in ascending slot order.
// A write is accepted and captured in S_IDLE; S_PRIM loads the primary result
// into the output register once that is free, then S_EVICT loads each reported
// eviction. The lookup runs combinationally through the row of stream cells;
// evictions are sent one per cycle from the same row unless the output stalls.
// s_tready is high only while no write is in progress.
// When the receiver stalls, the output register holds its result and the block
// waits; no result is lost.
// Reset (rst, synchronous): all streams invalid, event and sweep counters zero,
// registers at restart_threshold 4, sweep_period 50, idle_limit 200,
// report_removals 0. Config writes go through cfg_we/cfg_index/cfg_data.
module sequential_stream_detector
  import ssd_pkg::*;
#(
  parameter int STREAM_ENTRIES = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [15:0]  cfg_data,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [63:0]  s_tdata,   // address[31:0], timestamp[63:32]
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [143:0] m_tdata,   // stream_start[31:0], run_length[63:32],
                                  // repeat_count[79:64], first_time[111:80],
                                  // recent_time[143:112]
  output logic [2:0]   m_tuser,   // kind
  output logic         m_tlast
);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_PRIM  = 3'b010,
    S_EVICT = 3'b100
  } state_t;

  state_t      state;
  logic [15:0] threshold;
  logic [9:0]  period;
  logic [15:0] idle_limit;
  logic        report;
  logic [31:0] event_count;
  logic [9:0]  sweep_count;
  logic [9:0]  sweep_next;
  logic [31:0] addr;
  logic [31:0] ts;
  logic        sweep;

  cell_cmd_t                 cmd;
  chain_t                    chain [STREAM_ENTRIES+1];
  entry_t                    entries [STREAM_ENTRIES];
  logic [STREAM_ENTRIES-1:0] start_first;
  logic [STREAM_ENTRIES-1:0] ext_first;
  logic [STREAM_ENTRIES-1:0] free_first;
  logic [STREAM_ENTRIES-1:0] doom_first;
  logic [STREAM_ENTRIES-1:0] doom_now;
  logic [STREAM_ENTRIES-1:0] pick;
  logic [STREAM_ENTRIES-1:0] kill;

  logic   out_free;
  logic   accept;
  logic   prim_go;
  logic   evict_go;
  entry_t sel;
  entry_t start_sel;
  entry_t doom_sel;
  kind_t  kind;
  op_t    op;

  assign out_free   = !m_tvalid || m_tready;
  assign s_tready   = (state == S_IDLE);
  assign accept     = s_tvalid && s_tready;
  assign prim_go    = (state == S_PRIM) && out_free;
  assign evict_go   = (state == S_EVICT) && out_free;
  assign sweep_next = sweep_count + 10'd1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      threshold  <= 16'd4;
      period     <= 10'd50;
      idle_limit <= 16'd200;
      report     <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_THRESHOLD: threshold  <= cfg_data;
        REG_PERIOD:    period     <= cfg_data[9:0];
        REG_IDLE:      idle_limit <= cfg_data;
        REG_REPORT:    report     <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // capture the write and advance the sweep and event counters
  always_ff @(posedge clk) begin
    if (accept) begin
      addr  <= s_tdata[31:0];
      ts    <= s_tdata[63:32];
      sweep <= (sweep_next >= period);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sweep_count <= '0;
      event_count <= '0;
    end else begin
      if (accept) begin
        sweep_count <= (sweep_next >= period) ? 10'd0 : sweep_next;
      end
      if (prim_go) begin
        event_count <= event_count + 32'd1;
      end
    end
  end

  // select the winning entries from the row
  always_comb begin
    sel       = '0;
    start_sel = '0;
    doom_sel  = '0;
    for (int i = 0; i < STREAM_ENTRIES; i++) begin
      if (pick[i]) sel = sel | entries[i];
      if (start_first[i]) start_sel = start_sel | entries[i];
      if (doom_first[i]) doom_sel = doom_sel | entries[i];
    end
  end

  // classify the write
  always_comb begin
    if (chain[STREAM_ENTRIES].start_seen) begin
      pick = start_first;
      if (start_sel.length < {16'd0, threshold}) begin
        kind = KIND_BELOW;
        op   = OP_NONE;
      end else begin
        kind = KIND_RESTART;
        op   = OP_RESTART;
      end
    end else if (chain[STREAM_ENTRIES].ext_seen) begin
      pick = ext_first;
      kind = KIND_EXTENDED;
      op   = OP_EXTEND;
    end else if (chain[STREAM_ENTRIES].free_seen) begin
      pick = free_first;
      kind = KIND_NEW;
      op   = OP_OPEN;
    end else begin
      pick = '0;
      kind = KIND_FULL;
      op   = OP_NONE;
    end
  end

  always_comb begin
    cmd.op         = prim_go ? op : OP_NONE;
    cmd.addr       = addr;
    cmd.ts         = ts;
    cmd.event_num  = event_count;
    cmd.idle_limit = idle_limit;
    cmd.sweep      = sweep;
    cmd.mark       = prim_go && report;
    if (prim_go && !report) begin
      kill = doom_now;
    end else if (evict_go) begin
      kill = doom_first;
    end else begin
      kill = '0;
    end
  end

  assign chain[0] = '0;

  for (genvar g = 0; g < STREAM_ENTRIES; g++) begin : g_cell
    ssd_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .cmd         (cmd),
      .pick        (pick[g]),
      .kill        (kill[g]),
      .chain_in    (chain[g]),
      .chain_out   (chain[g+1]),
      .entry       (entries[g]),
      .start_first (start_first[g]),
      .ext_first   (ext_first[g]),
      .free_first  (free_first[g]),
      .doom_first  (doom_first[g]),
      .doom_now    (doom_now[g])
    );
  end

  // sequence one write
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE:  if (accept) state <= S_PRIM;
        S_PRIM:  if (prim_go) state <= (report && (|doom_now)) ? S_EVICT : S_IDLE;
        S_EVICT: if (evict_go && (chain[STREAM_ENTRIES].doom_cnt == 2'd1)) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (prim_go || evict_go) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (prim_go) begin
      m_tuser <= kind;
      m_tlast <= !(report && (|doom_now));
      case (kind)
        KIND_BELOW:
          m_tdata <= {sel.touch_time, sel.open_time, sel.repeats, sel.length, sel.start};
        KIND_RESTART:
          m_tdata <= {ts, sel.open_time,
                      (sel.repeats != 16'hFFFF) ? sel.repeats + 16'd1 : sel.repeats,
                      32'd1, sel.start};
        KIND_EXTENDED:
          m_tdata <= {ts, sel.open_time, sel.repeats,
                      (sel.length != 32'hFFFF_FFFF) ? sel.length + 32'd1 : sel.length,
                      sel.start};
        KIND_NEW:
          m_tdata <= {ts, ts, 16'd0, 32'd1, addr};
        default:
          m_tdata <= {ts, ts, 16'd0, 32'd0, addr};
      endcase
    end else if (evict_go) begin
      m_tuser <= KIND_EVICTED;
      m_tlast <= (chain[STREAM_ENTRIES].doom_cnt == 2'd1);
      m_tdata <= {ts, doom_sel.open_time, doom_sel.repeats, doom_sel.length, doom_sel.start};
    end
  end

`ifndef ASSERT_OFF
  a_start_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot0(start_first)) else $error("several start matches selected");
  a_accept_prim: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == S_PRIM)) else $error("accepted write not processed");
  a_evict_pending: assert property (@(posedge clk) disable iff (rst)
    (state == S_EVICT) |-> (chain[STREAM_ENTRIES].doom_cnt != 2'd0))
    else $error("eviction state without pending stream");
  a_kill_onehot: assert property (@(posedge clk) disable iff (rst)
    evict_go |-> $onehot(kill)) else $error("eviction must clear one stream");
`endif

endmodule
